// ===== rtl/core/bfsam_pkg.sv =====
// bfsam_pkg: shared types and constants for the bfs adjacency matrix order core
// no dependencies; used by bfsam_pick_unit and bfs_adjacency_matrix_order_core
`default_nettype none

package bfsam_pkg;

   // graph size is fixed by the 3-bit vertex fields and the 8-bit row mask
   localparam int VERTICES = 8;
   localparam int VERTEX_W = 3;
   localparam int COUNT_W  = VERTEX_W + 1;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef logic [VERTEX_W-1:0] vertex_type;
   typedef logic [VERTICES-1:0] row_type;
   typedef logic [COUNT_W-1:0]  count_type;

   typedef struct packed {
      logic       func;
      vertex_type row_index;
      row_type    row_bits;
      vertex_type start_vertex;
   } req_type;

   typedef struct packed {
      vertex_type vertex_id;
      logic       last;
   } rsp_type;

   // result of the shared lowest-set-bit search
   typedef struct packed {
      logic       found;
      vertex_type index;
   } pick_type;

endpackage

`default_nettype wire

// ===== rtl/core/bfsam_pick_unit.sv =====
// bfsam_pick_unit: finds the lowest unvisited neighbour in one adjacency row
// depends on bfsam_pkg
`default_nettype none

module bfsam_pick_unit (
   input  wire bfsam_pkg::row_type  row,
   input  wire bfsam_pkg::row_type  visited,
   output bfsam_pkg::pick_type      pick
);

   bfsam_pkg::row_type cand;

   // neighbours not yet visited
   assign cand = row & ~visited;

   // priority search, lowest column wins
   always_comb begin
      pick.found = |cand;
      pick.index = '0;
      for (int i = bfsam_pkg::VERTICES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            pick.index = bfsam_pkg::VERTEX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bfs_adjacency_matrix_order.sv =====
// bfs_adjacency_matrix_order_core: breadth-first order over a stored adjacency matrix
// depends on bfsam_pkg and bfsam_pick_unit
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  bfsam_pkg::req_type
//   rsp       out        rsp_valid/rsp_stall  bfsam_pkg::rsp_type
//
// a load writes its row as it is taken; a search keeps req stalled while it runs,
// stepping per vertex it emits through a row fetch and a scan step that finds nothing new,
// a pick step for each vertex but the root, then a last fetch and a flush
// reset (synchronous) clears the sequencer, visited mask, queue pointers and
// output valid; adjacency rows and queue entries hold no reset value
// a stalled rsp freezes the scan; req is stalled whenever a search is in progress
`default_nettype none

module bfs_adjacency_matrix_order_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire bfsam_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output bfsam_pkg::rsp_type     rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   bfsam_pkg::row_type   adj_ff [bfsam_pkg::VERTICES];
   bfsam_pkg::vertex_type queue_ff [bfsam_pkg::VERTICES];
   bfsam_pkg::row_type   visited_ff, visited_in;
   bfsam_pkg::count_type head_ff, head_in;
   bfsam_pkg::count_type tail_ff, tail_in;
   bfsam_pkg::row_type   row_ff, row_in;
   bfsam_pkg::vertex_type hold_ff, hold_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bfsam_pkg::rsp_type   rsp_ff, rsp_in;

   logic                 req_xfer;
   logic                 out_free;
   logic                 adj_we;
   logic                 queue_we;
   bfsam_pkg::vertex_type queue_wr_vertex;
   bfsam_pkg::pick_type  pick;

   // handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // shared lowest-unvisited-neighbour unit
   bfsam_pick_unit u_pick (
      .row     (row_ff),
      .visited (visited_ff),
      .pick    (pick)
   );

   // sequencer
   always_comb begin
      state_in        = state_ff;
      visited_in      = visited_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      row_in          = row_ff;
      hold_in         = hold_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      adj_we          = 1'b0;
      queue_we        = 1'b0;
      queue_wr_vertex = hold_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_data.func == bfsam_pkg::FUNC_LOAD) begin
                  adj_we = 1'b1;
               end else begin
                  visited_in      = bfsam_pkg::row_type'(1) << req_data.start_vertex;
                  queue_we        = 1'b1;
                  queue_wr_vertex = req_data.start_vertex;
                  head_in         = '0;
                  tail_in         = bfsam_pkg::count_type'(1);
                  hold_in         = req_data.start_vertex;
                  state_in        = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            if (head_ff == tail_ff) begin
               state_in = ST_FLUSH;
            end else begin
               row_in   = adj_ff[queue_ff[head_ff[bfsam_pkg::VERTEX_W-1:0]]];
               head_in  = head_ff + bfsam_pkg::count_type'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!pick.found) begin
               state_in = ST_FETCH;
            end else if (out_free) begin
               // emit the held vertex, hold the new one until we know if it is last
               visited_in      = visited_ff | (bfsam_pkg::row_type'(1) << pick.index);
               queue_we        = 1'b1;
               queue_wr_vertex = pick.index;
               tail_in         = tail_ff + bfsam_pkg::count_type'(1);
               rsp_in          = '{vertex_id: hold_ff, last: 1'b0};
               rsp_valid_in    = 1'b1;
               hold_in         = pick.index;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_in       = '{vertex_id: hold_ff, last: 1'b1};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         visited_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         visited_ff   <= visited_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers and storage
   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
      if (adj_we) begin
         adj_ff[req_data.row_index] <= req_data.row_bits;
      end
      if (queue_we) begin
         queue_ff[tail_in[bfsam_pkg::VERTEX_W-1:0] - bfsam_pkg::vertex_type'(1)] <=
            queue_wr_vertex;
      end
   end

`ifndef SYNTHESIS
   // every visited vertex has been queued exactly once
   a_visited_matches_tail: assert property (@(posedge clock) disable iff (reset)
      $countones(visited_ff) == 32'(tail_ff))
      else $error("visited count differs from queue tail");

   // the queue pointers stay in range: tail at most VERTICES, head never past tail
   a_tail_bounded: assert property (@(posedge clock) disable iff (reset)
      (tail_ff <= bfsam_pkg::count_type'(bfsam_pkg::VERTICES)) && (head_ff <= tail_ff))
      else $error("queue pointers out of range");

   // the vertex waiting to be emitted is always marked visited
   a_hold_visited: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> visited_ff[hold_ff])
      else $error("held vertex not visited");

   // a scan step that finds a neighbour with room at the output emits the held vertex, not last, next cycle
   a_scan_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && pick.found && out_free |=> rsp_valid_ff && !rsp_ff.last)
      else $error("scan step did not emit");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking bench for bfs_adjacency_matrix_order_core, breadth-first visit order
// depends on bfsam_pkg and the core; directed table first, then random load/search groups
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 40;
   localparam int RANDOM_ITEMS   = 226;

   // one row of the directed table; typed rows carry a one-vertex answer
   typedef struct packed {
      bfsam_pkg::req_type    req;
      logic                  typed;
      bfsam_pkg::vertex_type lone;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   bfsam_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   bfsam_pkg::rsp_type rsp_data;

   // local copy of the graph and the visits still owed by the core
   bfsam_pkg::row_type graph_rows [bfsam_pkg::VERTICES];
   bfsam_pkg::rsp_type expected_visits [$];

   int items_sent;
   int loads_sent;
   int searches_sent;
   int visits_checked;
   int mismatches;
   bit long_hold_done;

   bfs_adjacency_matrix_order_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic directed_row_type make_step(logic func, bfsam_pkg::vertex_type idx,
                                                  bfsam_pkg::row_type bits,
                                                  bfsam_pkg::vertex_type root, logic typed,
                                                  bfsam_pkg::vertex_type lone);
      directed_row_type s;
      s.req.func         = func;
      s.req.row_index    = idx;
      s.req.row_bits     = bits;
      s.req.start_vertex = root;
      s.typed            = typed;
      s.lone             = lone;
      return s;
   endfunction

   // breadth-first walk over the local graph copy, queues the visit order
   task automatic predict_search(input bfsam_pkg::vertex_type root);
      bfsam_pkg::row_type    seen;
      bfsam_pkg::vertex_type fifo [bfsam_pkg::VERTICES];
      bfsam_pkg::vertex_type order [$];
      bfsam_pkg::vertex_type v;
      int                    head;
      int                    tail;
      bfsam_pkg::rsp_type    e;
      seen       = '0;
      seen[root] = 1'b1;
      fifo[0]    = root;
      head       = 0;
      tail       = 1;
      order.push_back(root);
      while (head < tail) begin
         v = fifo[head];
         head++;
         for (int w = 0; w < bfsam_pkg::VERTICES; w++) begin
            if (graph_rows[v][w] && !seen[w]) begin
               seen[w]    = 1'b1;
               fifo[tail] = bfsam_pkg::vertex_type'(w);
               tail++;
               order.push_back(bfsam_pkg::vertex_type'(w));
            end
         end
      end
      foreach (order[i]) begin
         e.vertex_id = order[i];
         e.last      = (i == order.size() - 1);
         expected_visits.push_back(e);
      end
   endtask

   // account for one accepted request transfer
   task automatic record_transfer(input bfsam_pkg::req_type item, input logic typed,
                                  input bfsam_pkg::vertex_type lone);
      bfsam_pkg::rsp_type e;
      if (item.func == bfsam_pkg::FUNC_LOAD) begin
         graph_rows[item.row_index] = item.row_bits;
         loads_sent++;
      end else begin
         searches_sent++;
         if (typed) begin
            e.vertex_id = lone;
            e.last      = 1'b1;
            expected_visits.push_back(e);
         end else begin
            predict_search(item.start_vertex);
         end
      end
      items_sent++;
   endtask

   // offer one item after a random gap (none in every third run of 40 items) and hold it until the core takes it
   task automatic send_item(input bfsam_pkg::req_type item, input logic typed,
                            input bfsam_pkg::vertex_type lone);
      int gap;
      gap = ((items_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      record_transfer(item, typed, lone);
   endtask

   task automatic report_mismatch(input string what, input bfsam_pkg::rsp_type want,
                                  input bfsam_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch (%s) at %0t: expected vertex %0d last %0b, got vertex %0d last %0b",
                  what, $realtime, want.vertex_id, want.last, got.vertex_id, got.last);
   endtask

   // result side: compare every accepted transfer with the oldest expectation
   always @(posedge clock) begin
      bfsam_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_visits.size() == 0) begin
            want = '0;
            report_mismatch("unexpected result", want, rsp_data);
         end else begin
            want = expected_visits.pop_front();
            if (rsp_data.vertex_id !== want.vertex_id || rsp_data.last !== want.last)
               report_mismatch("field", want, rsp_data);
         end
         visits_checked++;
      end
   end

   // receiver stall pattern, with one long hold to back the core up
   initial begin
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         if (!long_hold_done && visits_checked >= 80) begin
            hold           = LONG_HOLD;
            long_hold_done = 1'b1;
         end else begin
            hold = ((visits_checked / 30) % 3 == 2) ? 0 : $urandom_range(0, 14);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // watchdog on cycles with no transfer on either channel
   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("timeout: no transfer for %0d cycles, %0d visits outstanding",
               WATCHDOG_LIMIT, expected_visits.size());
      $display("Regression FAIL");
      $finish;
   end

   // main sequence: reset, directed table, random groups, drain
   initial begin
      directed_row_type   directed_steps [$];
      bfsam_pkg::req_type item;
      int                 random_start;
      int                 n_loads;
      int                 n_searches;
      bit                 paused;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      items_sent     = 0;
      loads_sent     = 0;
      searches_sent  = 0;
      visits_checked = 0;
      mismatches     = 0;
      long_hold_done = 1'b0;
      paused         = 1'b0;

      // empty graph: each search returns just its root
      for (int r = 0; r < bfsam_pkg::VERTICES; r++)
         directed_steps.push_back(make_step(bfsam_pkg::FUNC_LOAD, bfsam_pkg::vertex_type'(r),
                                            8'h00, 3'd0, 1'b0, 3'd0));
      directed_steps.push_back(make_step(bfsam_pkg::FUNC_SEARCH, 3'd0, 8'h00, 3'd0,
                                         1'b1, 3'd0));
      directed_steps.push_back(make_step(bfsam_pkg::FUNC_SEARCH, 3'd7, 8'hFF, 3'd7,
                                         1'b1, 3'd7));
      // self loop alone changes nothing
      directed_steps.push_back(make_step(bfsam_pkg::FUNC_LOAD, 3'd3, 8'h08, 3'd0,
                                         1'b0, 3'd0));
      directed_steps.push_back(make_step(bfsam_pkg::FUNC_SEARCH, 3'd0, 8'h00, 3'd3,
                                         1'b1, 3'd3));
      // complete graph, then a sparse row into it
      for (int r = 0; r < bfsam_pkg::VERTICES; r++)
         directed_steps.push_back(make_step(bfsam_pkg::FUNC_LOAD, bfsam_pkg::vertex_type'(r),
                                            8'hFF, 3'd7, 1'b0, 3'd0));
      directed_steps.push_back(make_step(bfsam_pkg::FUNC_SEARCH, 3'd0, 8'h00, 3'd0,
                                         1'b0, 3'd0));
      directed_steps.push_back(make_step(bfsam_pkg::FUNC_SEARCH, 3'd0, 8'h00, 3'd7,
                                         1'b0, 3'd0));
      directed_steps.push_back(make_step(bfsam_pkg::FUNC_LOAD, 3'd4, 8'h81, 3'd0,
                                         1'b0, 3'd0));
      directed_steps.push_back(make_step(bfsam_pkg::FUNC_SEARCH, 3'd0, 8'h00, 3'd4,
                                         1'b0, 3'd0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         send_item(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].lone);

      // random groups: zero to three row loads, then one or two searches over the graph
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (!paused && items_sent - random_start >= 120) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_visits.size() != 0) @(posedge clock);
            paused = 1'b1;
         end
         n_loads = $urandom_range(0, 3);
         for (int k = 0; k < n_loads; k++) begin
            item.func         = bfsam_pkg::FUNC_LOAD;
            item.row_index    = bfsam_pkg::vertex_type'(
                                   $urandom_range(0, bfsam_pkg::VERTICES - 1));
            item.start_vertex = bfsam_pkg::vertex_type'($urandom);
            case ($urandom_range(0, 3))
               0: item.row_bits = bfsam_pkg::row_type'($urandom);
               1: item.row_bits = bfsam_pkg::row_type'($urandom & $urandom);
               2: item.row_bits = bfsam_pkg::row_type'(
                                     1 << $urandom_range(0, bfsam_pkg::VERTICES - 1));
               default: item.row_bits = bfsam_pkg::row_type'($urandom & $urandom & $urandom);
            endcase
            send_item(item, 1'b0, 3'd0);
         end
         n_searches = $urandom_range(1, 2);
         for (int k = 0; k < n_searches; k++) begin
            item.func         = bfsam_pkg::FUNC_SEARCH;
            item.row_index    = bfsam_pkg::vertex_type'($urandom);
            item.row_bits     = bfsam_pkg::row_type'($urandom);
            item.start_vertex = bfsam_pkg::vertex_type'(
                                   $urandom_range(0, bfsam_pkg::VERTICES - 1));
            send_item(item, 1'b0, 3'd0);
         end
      end
      req_valid <= 1'b0;

      // drain, then give the core time to show any stray result
      @(posedge clock);
      while (expected_visits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      foreach (expected_visits[i])
         report_mismatch("missing result", expected_visits[i], '0);
      $display("covered %0d row loads and %0d searches, %0d visits checked, %0d mismatches",
               loads_sent, searches_sent, visits_checked, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
